@@ rtl/cef_pkg.sv @@
// Shared types, constants and helper functions of the constraint edge crossing filter.
package cef_pkg;

  localparam int COORD_BITS    = 24;
  localparam int NODE_ID_BITS  = 16;
  localparam int INDEX_BITS    = 16;
  localparam int CFG_DATA_BITS = (COORD_BITS > NODE_ID_BITS) ? COORD_BITS : NODE_ID_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int NUM_ORIENT    = 9;

  typedef logic        [NODE_ID_BITS-1:0]   node_t;
  typedef logic signed [COORD_BITS-1:0]     coord_t;
  typedef logic signed [COORD_BITS:0]       diff_t;
  typedef logic signed [2*COORD_BITS+1:0]   prod_t;
  typedef logic signed [2*COORD_BITS+2:0]   det_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_NODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_NODE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_X    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y      = 3'd5;

  // Orientation of an ordered point triple
  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } ori_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] tri_index;
    node_t                 node_a;
    node_t                 node_b;
    node_t                 node_c;
    coord_t                vertex_a_x;
    coord_t                vertex_a_y;
    coord_t                vertex_b_x;
    coord_t                vertex_b_y;
    coord_t                vertex_c_x;
    coord_t                vertex_c_y;
    logic                  last_in;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] out_index;
    logic                  crosses;
    logic                  last_out;
  } out_item_t;

  typedef struct packed {
    node_t  start_node;
    node_t  end_node;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_cfg_t;

  // Operands of one orientation test: sign of a*b - c*d
  typedef struct packed {
    diff_t a;
    diff_t b;
    diff_t c;
    diff_t d;
  } ori_ops_t;

  // Per-triangle flags that ride alongside the orientation pipeline
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  last;
    logic                  skip_all;
    logic [2:0]            seg_node;
    logic [2:0]            v_in_seg_box;
    logic [2:0]            s_in_edge_box;
    logic [2:0]            e_in_edge_box;
  } side_t;

  function automatic diff_t coord_diff(input coord_t p, input coord_t q);
    coord_diff = diff_t'(p) - diff_t'(q);
  endfunction

  // q lies within the closed range spanned by p and r
  function automatic logic between(input coord_t p, input coord_t q, input coord_t r);
    between = ((q >= p) && (q <= r)) || ((q >= r) && (q <= p));
  endfunction

endpackage

@@ rtl/cef_front.sv @@
// Input stage: node matching, bounding-box tests and orientation operand differences.
module cef_front
  import cef_pkg::*;
(
  input  logic                          clk,
  input  logic                          ld,
  input  in_item_t                      item,
  input  seg_cfg_t                      seg,
  output ori_ops_t [NUM_ORIENT-1:0]     ops,
  output side_t                         side
);

  ori_ops_t [NUM_ORIENT-1:0] ops_nxt, ops_r;
  side_t                     side_nxt, side_r;
  node_t                     n  [3];
  coord_t                    x  [3];
  coord_t                    y  [3];
  logic  [2:0]               is_s;
  logic  [2:0]               is_e;

  always_comb begin
    n[0] = item.node_a;     n[1] = item.node_b;     n[2] = item.node_c;
    x[0] = item.vertex_a_x; x[1] = item.vertex_b_x; x[2] = item.vertex_c_x;
    y[0] = item.vertex_a_y; y[1] = item.vertex_b_y; y[2] = item.vertex_c_y;

    side_nxt.index = item.tri_index;
    side_nxt.last  = item.last_in;

    for (int i = 0; i < 3; i++) begin
      is_s[i] = (n[i] == seg.start_node);
      is_e[i] = (n[i] == seg.end_node);
      side_nxt.seg_node[i] = is_s[i] | is_e[i];
      side_nxt.v_in_seg_box[i] = between(seg.sx, x[i], seg.ex) && between(seg.sy, y[i], seg.ey);
      side_nxt.s_in_edge_box[i] = between(x[i], seg.sx, x[(i+1)%3]) &&
                                  between(y[i], seg.sy, y[(i+1)%3]);
      side_nxt.e_in_edge_box[i] = between(x[i], seg.ex, x[(i+1)%3]) &&
                                  between(y[i], seg.ey, y[(i+1)%3]);

      // segment S->E against vertex i
      ops_nxt[i].a = coord_diff(seg.ey, seg.sy);
      ops_nxt[i].b = coord_diff(x[i], seg.ex);
      ops_nxt[i].c = coord_diff(seg.ex, seg.sx);
      ops_nxt[i].d = coord_diff(y[i], seg.ey);
      // edge i->j against segment start
      ops_nxt[3+i].a = coord_diff(y[(i+1)%3], y[i]);
      ops_nxt[3+i].b = coord_diff(seg.sx, x[(i+1)%3]);
      ops_nxt[3+i].c = coord_diff(x[(i+1)%3], x[i]);
      ops_nxt[3+i].d = coord_diff(seg.sy, y[(i+1)%3]);
      // edge i->j against segment end
      ops_nxt[6+i].a = coord_diff(y[(i+1)%3], y[i]);
      ops_nxt[6+i].b = coord_diff(seg.ex, x[(i+1)%3]);
      ops_nxt[6+i].c = coord_diff(x[(i+1)%3], x[i]);
      ops_nxt[6+i].d = coord_diff(seg.ey, y[(i+1)%3]);
    end

    side_nxt.skip_all = (|is_s) & (|is_e);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ops_r  <= ops_nxt;
      side_r <= side_nxt;
    end
  end

  assign ops  = ops_r;
  assign side = side_r;

endmodule

@@ rtl/cef_orient.sv @@
// Two-stage exact orientation test: registered products, then registered sign.
module cef_orient
  import cef_pkg::*;
(
  input  logic     clk,
  input  logic     ld_mul,
  input  logic     ld_sign,
  input  ori_ops_t ops,
  output ori_t     ori
);

  prod_t ab_r, cd_r;
  det_t  det;
  ori_t  ori_nxt, ori_r;

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      ab_r <= prod_t'(ops.a) * prod_t'(ops.b);
      cd_r <= prod_t'(ops.c) * prod_t'(ops.d);
    end
  end

  always_comb begin
    det = det_t'(ab_r) - det_t'(cd_r);
    priority if (det == '0) begin
      ori_nxt = ORI_COL;
    end else if (det > 0) begin
      ori_nxt = ORI_CW;
    end else begin
      ori_nxt = ORI_CCW;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_sign) begin
      ori_r <= ori_nxt;
    end
  end

  assign ori = ori_r;

endmodule

@@ rtl/cef_decide.sv @@
// Edge selection and crossing decision from the nine orientation codes.
module cef_decide
  import cef_pkg::*;
(
  input  ori_t [NUM_ORIENT-1:0] ori,
  input  side_t                 side,
  output out_item_t             result
);

  logic [2:0] edge_hit;
  ori_t       o1, o2, o3, o4;
  logic       proper;

  always_comb begin
    edge_hit = '0;
    o1 = ORI_COL;
    o2 = ORI_COL;
    o3 = ORI_COL;
    o4 = ORI_COL;
    proper = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o1 = ori[i];
      o2 = ori[(i+1)%3];
      o3 = ori[3+i];
      o4 = ori[6+i];
      proper = (o1 != o2) && (o3 != o4);
      // drop edges touching a segment node
      edge_hit[i] = !side.seg_node[i] && !side.seg_node[(i+1)%3] &&
                    (proper ||
                     ((o1 == ORI_COL) && side.v_in_seg_box[i]) ||
                     ((o2 == ORI_COL) && side.v_in_seg_box[(i+1)%3]) ||
                     ((o3 == ORI_COL) && side.s_in_edge_box[i]) ||
                     ((o4 == ORI_COL) && side.e_in_edge_box[i]));
    end
    result.out_index = side.index;
    result.crosses   = !side.skip_all && (|edge_hit);
    result.last_out  = side.last;
  end

endmodule

@@ rtl/constraint_edge_crossing_filter.sv @@
// Top level of the constraint edge crossing filter.
// Takes one triangle transaction per clock while in_stall is low, and returns one result
// transaction per triangle, in order. The four register stages are: operand differences
// and box tests, the eighteen 25x25 multipliers, the determinant sign, and the
// decision/output register. Each stage holds only while the stage after it is full and
// stalled, so bubbles close up and input keeps flowing while a result waits. Configuration
// writes take effect at once and must be made with the pipeline empty.
module constraint_edge_crossing_filter
  import cef_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  seg_cfg_t                  seg_r;
  logic                      v1_r, v2_r, v3_r, v4_r;
  logic                      rdy1, rdy2, rdy3, rdy4;
  ori_ops_t [NUM_ORIENT-1:0] ops;
  ori_t     [NUM_ORIENT-1:0] ori;
  side_t                     side1, side2_r, side3_r;
  out_item_t                 result, out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_NODE: seg_r.start_node <= cfg_wdata[NODE_ID_BITS-1:0];
        REG_END_NODE:   seg_r.end_node   <= cfg_wdata[NODE_ID_BITS-1:0];
        REG_START_X:    seg_r.sx         <= cfg_wdata[COORD_BITS-1:0];
        REG_START_Y:    seg_r.sy         <= cfg_wdata[COORD_BITS-1:0];
        REG_END_X:      seg_r.ex         <= cfg_wdata[COORD_BITS-1:0];
        REG_END_Y:      seg_r.ey         <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the stage after it advances
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  cef_front u_front (
    .clk  (clk),
    .ld   (rdy1),
    .item (in_data),
    .seg  (seg_r),
    .ops  (ops),
    .side (side1)
  );

  for (genvar k = 0; k < NUM_ORIENT; k++) begin : g_ori
    cef_orient u_orient (
      .clk     (clk),
      .ld_mul  (rdy2),
      .ld_sign (rdy3),
      .ops     (ops[k]),
      .ori     (ori[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy2) side2_r <= side1;
    if (rdy3) side3_r <= side2_r;
  end

  cef_decide u_decide (
    .ori    (ori),
    .side   (side3_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rdy4) out_r <= result;
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

@@ bench/cef_checker.sv @@
// Checker for the constraint edge crossing filter: predicts each crossing verdict and compares.
`timescale 1ns / 1ps
module cef_checker
  import cef_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       errors,
  output int                       pending
);

  localparam int PRINT_LIMIT = 100;

  // Shadow copy of the segment registers
  node_t  seg_start_node, seg_end_node;
  longint seg_sx, seg_sy, seg_ex, seg_ey;

  out_item_t verdicts_due[$];

  // Turn of the triple p, q, r: sign of (qy-py)(rx-qx) - (qx-px)(ry-qy), exact in 64 bits
  function automatic ori_t turn_of(input longint px, input longint py,
                                   input longint qx, input longint qy,
                                   input longint rx, input longint ry);
    longint det;
    det = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (det == 0) return ORI_COL;
    return (det > 0) ? ORI_CW : ORI_CCW;
  endfunction

  function automatic bit spans(input longint p, input longint q, input longint r);
    return (p <= r) ? (q >= p && q <= r) : (q >= r && q <= p);
  endfunction

  function automatic bit edge_meets_segment(input longint ax, input longint ay,
                                            input longint bx, input longint by);
    ori_t o1, o2, o3, o4;
    o1 = turn_of(seg_sx, seg_sy, seg_ex, seg_ey, ax, ay);
    o2 = turn_of(seg_sx, seg_sy, seg_ex, seg_ey, bx, by);
    o3 = turn_of(ax, ay, bx, by, seg_sx, seg_sy);
    o4 = turn_of(ax, ay, bx, by, seg_ex, seg_ey);
    if (o1 != o2 && o3 != o4) return 1'b1;
    // collinear touching counts as a crossing
    if (o1 == ORI_COL && spans(seg_sx, ax, seg_ex) && spans(seg_sy, ay, seg_ey)) return 1'b1;
    if (o2 == ORI_COL && spans(seg_sx, bx, seg_ex) && spans(seg_sy, by, seg_ey)) return 1'b1;
    if (o3 == ORI_COL && spans(ax, seg_sx, bx) && spans(ay, seg_sy, by)) return 1'b1;
    if (o4 == ORI_COL && spans(ax, seg_ex, bx) && spans(ay, seg_ey, by)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit on_segment_node(input node_t n);
    return (n == seg_start_node) || (n == seg_end_node);
  endfunction

  function automatic out_item_t crossing_verdict(input in_item_t t);
    node_t     n[3];
    longint    x[3];
    longint    y[3];
    bit        has_start;
    bit        has_end;
    bit        hit;
    out_item_t v;
    n = '{t.node_a, t.node_b, t.node_c};
    x = '{longint'(t.vertex_a_x), longint'(t.vertex_b_x), longint'(t.vertex_c_x)};
    y = '{longint'(t.vertex_a_y), longint'(t.vertex_b_y), longint'(t.vertex_c_y)};
    has_start = 1'b0;
    has_end   = 1'b0;
    hit       = 1'b0;
    for (int i = 0; i < 3; i++) begin
      has_start |= (n[i] == seg_start_node);
      has_end   |= (n[i] == seg_end_node);
    end
    // a triangle holding both segment nodes never crosses
    if (!(has_start && has_end)) begin
      for (int i = 0; i < 3; i++) begin
        if (!hit && !on_segment_node(n[i]) && !on_segment_node(n[(i == 2) ? 0 : i + 1]))
          hit = edge_meets_segment(x[i], y[i], x[(i == 2) ? 0 : i + 1], y[(i == 2) ? 0 : i + 1]);
      end
    end
    v.out_index = t.tri_index;
    v.crosses   = hit;
    v.last_out  = t.last_in;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT)
      $display("%0t: %s", $time, msg);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      seg_start_node = '0;
      seg_end_node   = '0;
      seg_sx = 0;
      seg_sy = 0;
      seg_ex = 0;
      seg_ey = 0;
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_NODE: seg_start_node = node_t'(cfg_wdata);
          REG_END_NODE:   seg_end_node   = node_t'(cfg_wdata);
          REG_START_X:    seg_sx = longint'(coord_t'(cfg_wdata));
          REG_START_Y:    seg_sy = longint'(coord_t'(cfg_wdata));
          REG_END_X:      seg_ex = longint'(coord_t'(cfg_wdata));
          REG_END_Y:      seg_ey = longint'(coord_t'(cfg_wdata));
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        verdicts_due.insert(verdicts_due.size(), crossing_verdict(in_data));
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result transaction for index %0d with nothing outstanding",
                                    out_data.out_index));
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.out_index !== want.out_index)
            report_mismatch($sformatf("out_index: got %0d, expected %0d",
                                      out_data.out_index, want.out_index));
          if (out_data.crosses !== want.crosses)
            report_mismatch($sformatf("crosses for index %0d: got %b, expected %b",
                                      want.out_index, out_data.crosses, want.crosses));
          if (out_data.last_out !== want.last_out)
            report_mismatch($sformatf("last_out for index %0d: got %b, expected %b",
                                      want.out_index, out_data.last_out, want.last_out));
        end
      end
    end
    pending = verdicts_due.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the constraint edge crossing filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import cef_pkg::*;

  localparam int RESET_CYCLES   = 9;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 180;
  localparam int HOLD_AT        = 80;
  localparam int HOLD_CYCLES    = 64;
  localparam int DRAIN_TAIL     = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam node_t  NODE_MAX  = '1;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  int                       errors;
  int                       pending;
  int unsigned              sent;

  // Segment currently loaded, used to aim the triangles
  node_t  cur_start_node, cur_end_node;
  coord_t cur_sx, cur_sy, cur_ex, cur_ey;
  int     span;
  bit     burst;

  always #5 clk = ~clk;

  constraint_edge_crossing_filter dut (.*);

  cef_checker crossing_check (.*);

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic coord_t small_coord(input int lim);
    return coord_t'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic coord_t pick_scalar();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return COORD_MIN;
    if (r == 1) return COORD_MAX;
    if (span == 0) return coord_t'($urandom);
    return small_coord(span);
  endfunction

  // Favour the segment's own points so that touching and collinear cases turn up
  function automatic logic [2*COORD_BITS-1:0] pick_point();
    case ($urandom_range(0, 15))
      0, 1: return {cur_sx, cur_sy};
      2, 3: return {cur_ex, cur_ey};
      4: return {coord_t'((longint'(cur_sx) + longint'(cur_ex)) >>> 1),
                 coord_t'((longint'(cur_sy) + longint'(cur_ey)) >>> 1)};
      default: return {pick_scalar(), pick_scalar()};
    endcase
  endfunction

  function automatic node_t pick_node();
    case ($urandom_range(0, 7))
      0, 1: return cur_start_node;
      2, 3: return cur_end_node;
      4: return node_t'($urandom_range(0, 15));
      default: return node_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_triangle();
    in_item_t t;
    t.tri_index = INDEX_BITS'($urandom);
    t.node_a = pick_node();
    t.node_b = pick_node();
    t.node_c = pick_node();
    {t.vertex_a_x, t.vertex_a_y} = pick_point();
    {t.vertex_b_x, t.vertex_b_y} = pick_point();
    {t.vertex_c_x, t.vertex_c_y} = pick_point();
    t.last_in = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  function automatic in_item_t triangle_of(input int idx, input int na, input int nb,
                                           input int nc, input int ax, input int ay,
                                           input int bx, input int by, input int cx,
                                           input int cy, input bit last);
    in_item_t t;
    t.tri_index  = INDEX_BITS'(idx);
    t.node_a     = node_t'(na);
    t.node_b     = node_t'(nb);
    t.node_c     = node_t'(nc);
    t.vertex_a_x = coord_t'(ax);
    t.vertex_a_y = coord_t'(ay);
    t.vertex_b_x = coord_t'(bx);
    t.vertex_b_y = coord_t'(by);
    t.vertex_c_x = coord_t'(cx);
    t.vertex_c_y = coord_t'(cy);
    t.last_in    = last;
    return t;
  endfunction

  // Offer one triangle, hold it until accepted, then idle for a random gap (none in burst mode)
  task automatic offer(input in_item_t t);
    int unsigned gap;
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = burst ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_segment();
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    // upper bits of a node write must be dropped
    write_reg(REG_START_NODE, {junk[CFG_DATA_BITS-1:NODE_ID_BITS], cur_start_node});
    junk = CFG_DATA_BITS'($urandom);
    write_reg(REG_END_NODE, {junk[CFG_DATA_BITS-1:NODE_ID_BITS], cur_end_node});
    write_reg(REG_START_X, cur_sx);
    write_reg(REG_START_Y, cur_sy);
    write_reg(REG_END_X, cur_ex);
    write_reg(REG_END_Y, cur_ey);
    // spare indexes last, so any aliasing onto a real register shows up
    write_reg(REG_SPARE_6, CFG_DATA_BITS'($urandom));
    write_reg(REG_SPARE_7, CFG_DATA_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sent      = 0;
    span      = 0;
    burst     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: zero-length segment at the origin on node 0
    offer(triangle_of(0, 1, 2, 3, -4, -4, 4, 4, 4, -4, 1'b0));
    offer(triangle_of(NODE_MAX, 0, 2, 3, -4, -4, 4, 4, 4, -4, 1'b1));
    drain();

    cur_start_node = 5;
    cur_end_node   = 9;
    cur_sx = 0;
    cur_sy = 0;
    cur_ex = 10;
    cur_ey = 0;
    load_segment();
    offer(triangle_of(1, 100, 101, 102, 3, -5, 3, 5, -5, -5, 1'b0));
    offer(triangle_of(2, 100, 101, 102, 20, 20, 30, 20, 25, 30, 1'b0));
    offer(triangle_of(3, 5, 9, 100, 3, -5, 3, 5, -5, -5, 1'b0));
    offer(triangle_of(4, 9, 100, 5, 3, -5, 3, 5, -5, -5, 1'b1));
    offer(triangle_of(5, 5, 101, 102, -5, -5, 3, -5, 3, 5, 1'b0));
    offer(triangle_of(6, 101, 5, 102, 3, -5, 3, 5, 20, 20, 1'b0));
    offer(triangle_of(7, 101, 102, 9, 3, -5, 3, 5, 20, 20, 1'b0));
    offer(triangle_of(8, 100, 101, 102, 2, 0, 4, 0, 3, 7, 1'b0));
    offer(triangle_of(9, 100, 101, 102, 12, 0, 15, 0, 13, 4, 1'b0));
    offer(triangle_of(10, 100, 101, 102, 5, 0, 6, 3, 4, 3, 1'b0));
    offer(triangle_of(11, 100, 101, 102, 10, 0, 12, 3, 12, -3, 1'b0));
    offer(triangle_of(12, 100, 101, 102, 10, -3, 10, 3, 14, 0, 1'b0));
    offer(triangle_of(13, 100, 101, 102, 5, 0, 5, 0, 20, 20, 1'b0));
    offer(triangle_of(14, 100, 101, 102, 5, 1, 5, 1, 5, 1, 1'b0));
    offer(triangle_of(15, 100, 101, 102, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                      0, COORD_MAX, 1'b0));
    offer(triangle_of(16, 0, NODE_MAX, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                      COORD_MAX, COORD_MAX, 1'b1));
    offer(triangle_of(NODE_MAX, NODE_MAX, NODE_MAX, NODE_MAX, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1));
    offer(triangle_of(0, 100, 101, 102, -1, 0, 11, 0, 5, -1, 1'b1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      burst = 1'b0;
      span  = 0;
      case (ph)
        0: begin
          cur_start_node = node_t'($urandom_range(0, 15));
          cur_end_node   = node_t'($urandom_range(0, 15));
          cur_sx = small_coord(20);
          cur_sy = small_coord(20);
          cur_ex = small_coord(20);
          cur_ey = small_coord(20);
          span   = 24;
        end
        1: begin
          cur_start_node = '0;
          cur_end_node   = NODE_MAX;
          cur_sx = COORD_MIN;
          cur_sy = COORD_MIN;
          cur_ex = COORD_MAX;
          cur_ey = COORD_MAX;
        end
        2: begin
          // both ends on one node
          cur_start_node = node_t'($urandom_range(0, 15));
          cur_end_node   = cur_start_node;
          cur_sx = small_coord(12);
          cur_sy = small_coord(12);
          cur_ex = small_coord(12);
          cur_ey = small_coord(12);
          span   = 16;
        end
        3: begin
          // zero-length segment
          cur_start_node = node_t'($urandom_range(0, 15));
          cur_end_node   = node_t'($urandom_range(0, 15));
          cur_sx = small_coord(8);
          cur_sy = small_coord(8);
          cur_ex = cur_sx;
          cur_ey = cur_sy;
          span   = 10;
        end
        4: begin
          cur_start_node = node_t'($urandom);
          cur_end_node   = node_t'($urandom);
          cur_sx = coord_t'($urandom);
          cur_sy = coord_t'($urandom);
          cur_ex = coord_t'($urandom);
          cur_ey = coord_t'($urandom);
          burst  = 1'b1;
        end
        5: begin
          cur_start_node = NODE_MAX;
          cur_end_node   = '0;
          cur_sx = COORD_MAX;
          cur_sy = COORD_MIN;
          cur_ex = COORD_MIN;
          cur_ey = COORD_MAX;
        end
        6: begin
          cur_start_node = node_t'($urandom_range(0, 15));
          cur_end_node   = node_t'($urandom_range(0, 15));
          cur_sx = small_coord(6);
          cur_sy = small_coord(6);
          cur_ex = small_coord(6);
          cur_ey = small_coord(6);
          span   = 8;
        end
        default: begin
          cur_start_node = node_t'($urandom);
          cur_end_node   = node_t'($urandom);
          cur_sx = small_coord(1000);
          cur_sy = small_coord(1000);
          cur_ex = small_coord(1000);
          cur_ey = small_coord(1000);
          span   = 1200;
        end
      endcase
      load_segment();
      repeat (PHASE_ITEMS) offer(random_triangle());
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS constraint_edge_crossing_filter");
    else
      $display("FAIL constraint_edge_crossing_filter");
    $finish;
  end

  // Random stalls on the result side, with one long hold-off to fill the pipeline
  initial begin : result_backpressure
    int unsigned stall_len;
    int unsigned free_len;
    bit          held;
    out_stall = 1'b0;
    held      = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && sent >= HOLD_AT) begin
        held      = 1'b1;
        stall_len = HOLD_CYCLES;
        free_len  = 1;
      end else begin
        stall_len = idle_len();
        free_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 6);
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL constraint_edge_crossing_filter");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cef_pkg.sv
rtl/cef_front.sv
rtl/cef_orient.sv
rtl/cef_decide.sv
rtl/constraint_edge_crossing_filter.sv
bench/cef_checker.sv
bench/tb.sv
